FILE: rtl/thread_ready_queue_macros.svh
// ----------------------------------------------------------------------------
// thread ready queue assertion macros
// same-cycle and next-cycle implication checks on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef THREAD_READY_QUEUE_MACROS_SVH
`define THREAD_READY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define TRQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trq check failed");

// antecedent implies consequent in the next cycle
`define TRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trq check failed");

`else

`define TRQ_ASSERT_SAME(label, ante, cons)
`define TRQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/trq_pkg.sv
// ----------------------------------------------------------------------------
// trq_pkg
// shared sizes, codes and control types of the thread ready queue
// ----------------------------------------------------------------------------
`default_nettype none

package trq_pkg;

  localparam int MAX_THREADS   = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int STATE_BITS    = 4;

  // fixed port field widths
  localparam int CMD_W     = 2;
  localparam int ID_W      = 4;
  localparam int PRIO_IN_W = 8;
  localparam int STATE_IN_W = 4;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  // derived sizes
  localparam int IDX_W  = $clog2(MAX_THREADS);
  localparam int CNT_W  = $clog2(MAX_THREADS + 1);
  localparam int TREE_N = 1 << IDX_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH       = 2'd0,
    CMD_PULL_PRIO  = 2'd1,
    CMD_PULL_ID    = 2'd2,
    CMD_PULL_STATE = 2'd3
  } cmd_t;

  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic [PRIORITY_BITS-1:0] prio;
    logic [STATE_BITS-1:0]    st;
  } cell_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_hold;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/trq_dp.sv
// ----------------------------------------------------------------------------
// trq_dp
// queue cells, selection tree, shift/append update and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "thread_ready_queue_macros.svh"

module trq_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire trq_pkg::dp_cmd_t               cmd,
  output trq_pkg::dp_sts_t                    sts,
  input  wire logic [trq_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [trq_pkg::ID_W-1:0]       in_thread_id,
  input  wire logic [trq_pkg::PRIO_IN_W-1:0]  in_priority_req,
  input  wire logic [trq_pkg::STATE_IN_W-1:0] in_thread_state,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [trq_pkg::STATUS_W-1:0]        out_status,
  output logic [trq_pkg::ID_W-1:0]            out_id,
  output logic [trq_pkg::PRIO_IN_W-1:0]       out_priority,
  output logic [trq_pkg::STATE_IN_W-1:0]      out_state,
  output logic [trq_pkg::OCC_W-1:0]           out_occupancy
);

  import trq_pkg::*;

  cell_t                    cells_r [MAX_THREADS];
  cell_t                    cells_nxt [MAX_THREADS];
  logic [CNT_W-1:0]         count_r, count_nxt;

  cmd_t                     op_r;
  cell_t                    new_r;
  logic [IDX_W-1:0]         pos_r;
  logic                     found_r;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  cell_t                    res_r, res_nxt;

  logic [PRIORITY_BITS-1:0] node_key [1:2*TREE_N-1];
  logic [IDX_W-1:0]         node_idx [1:2*TREE_N-1];
  cell_t                    in_cell;

  assign in_cell.id   = in_thread_id;
  assign in_cell.prio = PRIORITY_BITS'(in_priority_req);
  assign in_cell.st   = STATE_BITS'(in_thread_state);

  // selection tree: leaves carry a key, the left child wins unless the right is
  // strictly larger, so the earliest best entry comes out on top
  always_comb begin
    for (int k = 0; k < TREE_N; k++) begin
      node_key[TREE_N+k] = '0;
      node_idx[TREE_N+k] = IDX_W'(k);
    end
    for (int k = 0; k < MAX_THREADS; k++) begin
      if (CNT_W'(k) < count_r) begin
        case (cmd_t'(in_cmd))
          CMD_PULL_PRIO:  node_key[TREE_N+k] = cells_r[k].prio;
          CMD_PULL_ID:    node_key[TREE_N+k] =
                            PRIORITY_BITS'(cells_r[k].id == in_cell.id);
          CMD_PULL_STATE: node_key[TREE_N+k] =
                            PRIORITY_BITS'(cells_r[k].st == in_cell.st);
          default:        node_key[TREE_N+k] = '0;
        endcase
      end
    end
    for (int i = TREE_N - 1; i >= 1; i--) begin
      if (node_key[2*i+1] > node_key[2*i]) begin
        node_key[i] = node_key[2*i+1];
        node_idx[i] = node_idx[2*i+1];
      end else begin
        node_key[i] = node_key[2*i];
        node_idx[i] = node_idx[2*i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= cmd_t'(in_cmd);
      new_r   <= in_cell;
      pos_r   <= node_idx[1];
      found_r <= (node_key[1] != '0);
    end
  end

  // commit: append on push, close the gap on a removal
  always_comb begin
    cells_nxt  = cells_r;
    count_nxt  = count_r;
    status_nxt = STATUS_NONE;
    res_nxt    = '0;
    if (op_r == CMD_PUSH) begin
      if (count_r == CNT_W'(MAX_THREADS)) begin
        status_nxt = STATUS_FULL;
      end else begin
        status_nxt = STATUS_DONE;
        count_nxt  = count_r + CNT_W'(1);
        for (int k = 0; k < MAX_THREADS; k++) begin
          if (count_r == CNT_W'(k)) begin
            cells_nxt[k] = new_r;
          end
        end
      end
    end else if (found_r) begin
      status_nxt = STATUS_DONE;
      res_nxt    = cells_r[pos_r];
      count_nxt  = count_r - CNT_W'(1);
      for (int k = 0; k < MAX_THREADS - 1; k++) begin
        if (IDX_W'(k) >= pos_r) begin
          cells_nxt[k] = cells_r[k+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      cells_r  <= cells_nxt;
      status_r <= status_nxt;
      res_r    <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_hold   = out_valid_r && !out_ready;

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_id         = res_r.id;
  assign out_priority   = PRIO_IN_W'(res_r.prio);
  assign out_state      = STATE_IN_W'(res_r.st);
  assign out_occupancy  = OCC_W'(count_r);

  `TRQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_THREADS))
  `TRQ_ASSERT_SAME(a_commit_free, cmd.commit, !(out_valid_r && !out_ready))
  `TRQ_ASSERT_NEXT(a_pull_count, cmd.commit && op_r != CMD_PUSH && found_r,
                   count_r == $past(count_r) - CNT_W'(1))

endmodule

`default_nettype wire

FILE: rtl/trq_ctrl.sv
// ----------------------------------------------------------------------------
// trq_ctrl
// two-state sequencer: accept and search, then commit into the result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "thread_ready_queue_macros.svh"

module trq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output trq_pkg::dp_cmd_t      cmd,
  input  wire trq_pkg::dp_sts_t sts
);

  import trq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_COMMIT = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!sts.out_hold) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TRQ_ASSERT_NEXT(a_accept_to_commit, state_r == ST_IDLE && in_valid,
                   state_r == ST_COMMIT)
  `TRQ_ASSERT_NEXT(a_commit_to_idle, state_r == ST_COMMIT && !sts.out_hold,
                   state_r == ST_IDLE)

endmodule

`default_nettype wire

FILE: rtl/thread_ready_queue.sv
// ----------------------------------------------------------------------------
// thread_ready_queue
// ordered thread ready queue with push and three kinds of pull
// ----------------------------------------------------------------------------
// Each request is searched, then committed: in the cycle it is accepted a
// compare tree over all queue cells picks the entry to remove (earliest
// strictly highest non-zero priority, or first matching id or state), and in
// the commit state the cells shift to close the gap (or the new entry is
// appended) and the result is loaded into the output register. A new request
// is taken the cycle after the commit, even while the previous result still
// waits in the output register; the commit cycle only stalls when a result is
// still unread. Requests do not overlap: the next is accepted only after the
// previous one commits. No clearing pass after reset.
`default_nettype none

module thread_ready_queue (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [trq_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [trq_pkg::ID_W-1:0]       in_thread_id,
  input  wire logic [trq_pkg::PRIO_IN_W-1:0]  in_priority_req,
  input  wire logic [trq_pkg::STATE_IN_W-1:0] in_thread_state,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [trq_pkg::STATUS_W-1:0]        out_status,
  output logic [trq_pkg::ID_W-1:0]            out_id,
  output logic [trq_pkg::PRIO_IN_W-1:0]       out_priority,
  output logic [trq_pkg::STATE_IN_W-1:0]      out_state,
  output logic [trq_pkg::OCC_W-1:0]           out_occupancy
);

  import trq_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencer: accept, then commit when the result register is free
  trq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (dp_cmd),
    .sts      (dp_sts)
  );

  // cells, selection tree and result register
  trq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .sts             (dp_sts),
    .in_cmd          (in_cmd),
    .in_thread_id    (in_thread_id),
    .in_priority_req (in_priority_req),
    .in_thread_state (in_thread_state),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_id          (out_id),
    .out_priority    (out_priority),
    .out_state       (out_state),
    .out_occupancy   (out_occupancy)
  );

endmodule

`default_nettype wire

FILE: dv/thread_ready_queue_tb.sv
// ----------------------------------------------------------------------------
// thread_ready_queue_tb
// Drives push and pull requests into the thread ready queue over the
// valid/ready request channel and checks every result against a typed directed
// result or a predictor that keeps its own copy of the queued threads. A short
// table of directed requests is followed by random requests in several blocks
// with differing push bias and idling, one long result hold-off and one full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module thread_ready_queue_tb;

  import trq_pkg::*;

  // one request as offered on the input channel
  typedef struct packed {
    cmd_t                  cmd;
    logic [ID_W-1:0]       id;
    logic [PRIO_IN_W-1:0]  prio;
    logic [STATE_IN_W-1:0] st;
  } request_t;

  // one result as seen on the output channel
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [ID_W-1:0]       id;
    logic [PRIO_IN_W-1:0]  prio;
    logic [STATE_IN_W-1:0] st;
    logic [OCC_W-1:0]      occupancy;
  } queue_result_t;

  // directed row: request, repeat count, and a typed result where it is obvious
  typedef struct packed {
    cmd_t                  cmd;
    logic [ID_W-1:0]       id;
    logic [PRIO_IN_W-1:0]  prio;
    logic [STATE_IN_W-1:0] st;
    logic [4:0]            reps;
    logic                  typed;
    logic [STATUS_W-1:0]   r_status;
    logic [ID_W-1:0]       r_id;
    logic [PRIO_IN_W-1:0]  r_prio;
    logic [STATE_IN_W-1:0] r_st;
    logic [OCC_W-1:0]      r_occ;
  } directed_row_t;

  localparam int DIRECTED_N = 17;

  localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    // empty queue: every kind of pull finds nothing
    '{CMD_PULL_PRIO,  4'd0,  8'd0,   4'd0,  5'd1,  1'b1, STATUS_NONE, 4'd0, 8'd0, 4'd0, 5'd0},
    '{CMD_PULL_ID,    4'd0,  8'd0,   4'd0,  5'd1,  1'b1, STATUS_NONE, 4'd0, 8'd0, 4'd0, 5'd0},
    '{CMD_PULL_STATE, 4'd15, 8'd255, 4'd15, 5'd1,  1'b1, STATUS_NONE, 4'd0, 8'd0, 4'd0, 5'd0},
    // a zero priority thread is never picked by priority
    '{CMD_PUSH,       4'd0,  8'd0,   4'd0,  5'd1,  1'b1, STATUS_DONE, 4'd0, 8'd0, 4'd0, 5'd1},
    '{CMD_PULL_PRIO,  4'd15, 8'd255, 4'd15, 5'd1,  1'b1, STATUS_NONE, 4'd0, 8'd0, 4'd0, 5'd1},
    // two threads tied on the top priority, and a duplicate id
    '{CMD_PUSH,       4'd15, 8'd255, 4'd15, 5'd1,  1'b1, STATUS_DONE, 4'd0, 8'd0, 4'd0, 5'd2},
    '{CMD_PUSH,       4'd3,  8'd255, 4'd5,  5'd1,  1'b1, STATUS_DONE, 4'd0, 8'd0, 4'd0, 5'd3},
    '{CMD_PUSH,       4'd15, 8'd7,   4'd9,  5'd1,  1'b1, STATUS_DONE, 4'd0, 8'd0, 4'd0, 5'd4},
    // earliest of the tied, the remaining copy of the id, then by state
    '{CMD_PULL_PRIO,  4'd0,  8'd0,   4'd0,  5'd1,  1'b0, STATUS_DONE, 4'd0, 8'd0, 4'd0, 5'd0},
    '{CMD_PULL_ID,    4'd15, 8'd0,   4'd0,  5'd1,  1'b0, STATUS_DONE, 4'd0, 8'd0, 4'd0, 5'd0},
    '{CMD_PULL_STATE, 4'd0,  8'd0,   4'd5,  5'd1,  1'b0, STATUS_DONE, 4'd0, 8'd0, 4'd0, 5'd0},
    // an id that was never queued and a state that is no longer queued
    '{CMD_PULL_ID,    4'd9,  8'd0,   4'd0,  5'd1,  1'b0, STATUS_DONE, 4'd0, 8'd0, 4'd0, 5'd0},
    '{CMD_PULL_STATE, 4'd0,  8'd0,   4'd9,  5'd1,  1'b0, STATUS_DONE, 4'd0, 8'd0, 4'd0, 5'd0},
    // fill the queue to the top, then one push too many
    '{CMD_PUSH,       4'd10, 8'd1,   4'd10, 5'd15, 1'b0, STATUS_DONE, 4'd0, 8'd0, 4'd0, 5'd0},
    '{CMD_PUSH,       4'd5,  8'd200, 4'd6,  5'd1,  1'b1, STATUS_FULL, 4'd0, 8'd0, 4'd0, 5'd16},
    // pull from a full queue: priority skips the zero at the head
    '{CMD_PULL_PRIO,  4'd0,  8'd0,   4'd0,  5'd1,  1'b0, STATUS_DONE, 4'd0, 8'd0, 4'd0, 5'd0},
    '{CMD_PULL_STATE, 4'd0,  8'd0,   4'd0,  5'd1,  1'b0, STATUS_DONE, 4'd0, 8'd0, 4'd0, 5'd0}
  };

  localparam int RANDOM_BLOCKS = 6;
  localparam int BLOCK_ITEMS   = 250;
  localparam int HOLD_CYCLES   = 200;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  // dut ports
  logic                  in_valid;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_cmd;
  logic [ID_W-1:0]       in_thread_id;
  logic [PRIO_IN_W-1:0]  in_priority_req;
  logic [STATE_IN_W-1:0] in_thread_state;
  logic                  out_valid;
  logic                  out_ready;
  logic [STATUS_W-1:0]   out_status;
  logic [ID_W-1:0]       out_id;
  logic [PRIO_IN_W-1:0]  out_priority;
  logic [STATE_IN_W-1:0] out_state;
  logic [OCC_W-1:0]      out_occupancy;

  // predictor state: the queued threads in order, oldest first
  cell_t         queued_threads [$];
  // results still owed by the dut, oldest first
  queue_result_t awaited_results [$];

  int mismatch_count = 0;

  // idling knobs, set per block by the stimulus process
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int push_pct = 50;
  int ready_hold_cycles = 0;

  thread_ready_queue dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_thread_id    (in_thread_id),
    .in_priority_req (in_priority_req),
    .in_thread_state (in_thread_state),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_id          (out_id),
    .out_priority    (out_priority),
    .out_state       (out_state),
    .out_occupancy   (out_occupancy)
  );

  // applies one accepted request to the predicted queue and returns its result
  function automatic queue_result_t run_request(input request_t req);
    queue_result_t            res;
    cell_t                    pushed;
    logic [PRIORITY_BITS-1:0] best;
    int                       pos;
    res = '0;
    res.status = STATUS_NONE;
    best = '0;
    pos = -1;
    case (req.cmd)
      CMD_PUSH: begin
        if (queued_threads.size() >= MAX_THREADS) begin
          res.status = STATUS_FULL;
        end else begin
          pushed.id = req.id;
          pushed.prio = req.prio[PRIORITY_BITS-1:0];
          pushed.st = req.st[STATE_BITS-1:0];
          queued_threads.push_back(pushed);
          res.status = STATUS_DONE;
        end
      end
      CMD_PULL_PRIO: begin
        // strictly greater keeps the earliest of equal priorities, zero never wins
        for (int k = 0; k < queued_threads.size(); k++) begin
          if (queued_threads[k].prio > best) begin
            best = queued_threads[k].prio;
            pos = k;
          end
        end
      end
      CMD_PULL_ID: begin
        for (int k = 0; k < queued_threads.size(); k++) begin
          if (pos < 0 && queued_threads[k].id == req.id) pos = k;
        end
      end
      default: begin
        for (int k = 0; k < queued_threads.size(); k++) begin
          if (pos < 0 && queued_threads[k].st == req.st[STATE_BITS-1:0]) pos = k;
        end
      end
    endcase
    if (pos >= 0) begin
      res.status = STATUS_DONE;
      res.id = queued_threads[pos].id;
      res.prio = PRIO_IN_W'(queued_threads[pos].prio);
      res.st = STATE_IN_W'(queued_threads[pos].st);
      // removal closes the gap, order of the rest is kept
      queued_threads.delete(pos);
    end
    res.occupancy = OCC_W'(queued_threads.size());
    return res;
  endfunction

  // random request; pulls mostly aim at threads that are actually queued
  function automatic request_t random_request();
    request_t req;
    int       pick;
    req.cmd = cmd_t'(CMD_W'($urandom_range(1, 3)));
    if ($urandom_range(0, 99) < push_pct) req.cmd = CMD_PUSH;
    req.id = ID_W'($urandom);
    req.prio = PRIO_IN_W'($urandom);
    req.st = STATE_IN_W'($urandom);
    // a narrow priority band makes ties and zero priorities common
    if ($urandom_range(0, 1) == 0) req.prio = PRIO_IN_W'($urandom_range(0, 3));
    if (req.cmd != CMD_PUSH && queued_threads.size() > 0 && $urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, queued_threads.size() - 1);
      req.id = queued_threads[pick].id;
      req.st = STATE_IN_W'(queued_threads[pick].st);
    end
    return req;
  endfunction

  // offers one request from a falling edge, waits for the handshake, records
  // the expected result at the accepting edge and returns on the next falling edge
  task automatic send_request(input request_t req, input bit use_typed,
                              input queue_result_t typed_result);
    int            gap;
    queue_result_t predicted;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = req.cmd;
    in_thread_id = req.id;
    in_priority_req = req.prio;
    in_thread_state = req.st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // predictor always runs so its queue stays in step with the dut
    predicted = run_request(req);
    awaited_results.push_back(use_typed ? typed_result : predicted);
    @(negedge clk);
  endtask

  // stops offering and waits until every owed result has come back
  task automatic wait_for_drain();
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  task automatic report_result_error(input string what, input queue_result_t want,
                                     input queue_result_t seen);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected status %0d id %0d prio %0d state %0d occ %0d",
               $realtime, what, want.status, want.id, want.prio, want.st, want.occupancy);
      $display("%0t %s: actual   status %0d id %0d prio %0d state %0d occ %0d",
               $realtime, what, seen.status, seen.id, seen.prio, seen.st, seen.occupancy);
    end
  endtask

  // result checker: compares every accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    queue_result_t seen;
    queue_result_t want;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_status, out_id, out_priority, out_state, out_occupancy};
      if (awaited_results.size() == 0) begin
        report_result_error("result with no request pending", '0, seen);
      end else begin
        want = awaited_results.pop_front();
        if (seen.status != want.status || seen.id != want.id || seen.prio != want.prio ||
            seen.st != want.st || seen.occupancy != want.occupancy) begin
          report_result_error("result mismatch", want, seen);
        end
      end
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int burst;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (ready_hold_cycles > 0) begin
        // long hold-off counted here so the sender keeps offering meanwhile
        out_ready = 1'b0;
        repeat (ready_hold_cycles) @(negedge clk);
        ready_hold_cycles = 0;
        out_ready = 1'b1;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        burst = $urandom_range(1, 16);
        out_ready = 1'b0;
        repeat (burst) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // request side: reset, directed table, random blocks, final drain
  initial begin : stimulus
    request_t      req;
    queue_result_t typed;
    in_valid = 1'b0;
    in_cmd = CMD_PUSH;
    in_thread_id = '0;
    in_priority_req = '0;
    in_thread_state = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table with light idling on both sides
    send_idle_pct = 25;
    recv_idle_pct = 8;
    for (int row = 0; row < DIRECTED_N; row++) begin
      req.cmd = DIRECTED_ROWS[row].cmd;
      req.id = DIRECTED_ROWS[row].id;
      req.prio = DIRECTED_ROWS[row].prio;
      req.st = DIRECTED_ROWS[row].st;
      typed.status = DIRECTED_ROWS[row].r_status;
      typed.id = DIRECTED_ROWS[row].r_id;
      typed.prio = DIRECTED_ROWS[row].r_prio;
      typed.st = DIRECTED_ROWS[row].r_st;
      typed.occupancy = DIRECTED_ROWS[row].r_occ;
      repeat (DIRECTED_ROWS[row].reps) send_request(req, DIRECTED_ROWS[row].typed, typed);
    end

    // random blocks, each with its own push bias and idling
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case (blk)
        0: begin
          push_pct = 60;
          send_idle_pct = 20;
          recv_idle_pct = 10;
        end
        1: begin
          // sender keeps offering back to back while results are held off,
          // so the output register fills and the request channel stalls
          push_pct = 75;
          send_idle_pct = 0;
          recv_idle_pct = 0;
          ready_hold_cycles = HOLD_CYCLES;
        end
        2: begin
          // drain-heavy mix to revisit the empty queue
          push_pct = 25;
          send_idle_pct = 35;
          recv_idle_pct = 15;
        end
        3: begin
          wait_for_drain();
          push_pct = 50;
          send_idle_pct = 50;
          recv_idle_pct = 3;
        end
        4: begin
          push_pct = 65;
          send_idle_pct = 10;
          recv_idle_pct = 20;
        end
        default: begin
          // last stretch runs with no idling at all
          push_pct = 48;
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (BLOCK_ITEMS) begin
        req = random_request();
        send_request(req, 1'b0, '0);
      end
    end

    wait_for_drain();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin : run_limit
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: thread_ready_queue.f
+incdir+rtl
rtl/trq_pkg.sv
rtl/trq_dp.sv
rtl/trq_ctrl.sv
rtl/thread_ready_queue.sv
dv/thread_ready_queue_tb.sv
